/* design/pdts_pkg.sv */
// Package for the priority dispatcher with timed servers.
// Holds sizes, result kind codes, payload structs and the
// controller/datapath command and status structs. No dependencies.
package pdts_pkg;

    // Sizes
    localparam int SERVERS     = 3;
    localparam int CLASS_DEPTH = 64;
    localparam int NUM_CLASSES = 3;

    localparam int CLS_W   = 2;
    localparam int NUM_W   = 16;
    localparam int DUR_W   = 16;
    localparam int SRVF_W  = 2;
    localparam int SRV_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int PTR_W   = $clog2(CLASS_DEPTH);
    localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int ENTRY_W = NUM_W + DUR_W;

    // Input command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ASSIGN    = 2'd0,
        KIND_TICK_DONE = 2'd1,
        KIND_ENQ_OK    = 2'd2,
        KIND_ENQ_FULL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic               command;
        logic [CLS_W-1:0]   customer_class;
        logic [NUM_W-1:0]   customer_number;
        logic [DUR_W-1:0]   call_duration;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [CLS_W-1:0]   job_class;
        logic [NUM_W-1:0]   job_number;
        logic [SRVF_W-1:0]  server_index;
        logic               work_pending;
        logic               last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction, restart the server scan
        logic enq;        // store or reject the held job, emit its result
        logic srv_next;   // advance to the next server
        logic pop;        // read and remove the head of the best class
        logic assign_job; // load the popped duration into the server, emit assignment
        logic status;     // count down busy servers, emit tick status
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic srv_busy;
        logic srv_last;
        logic any_class;
        logic out_free;
    } t_status;

endpackage

/* design/pdts_ctrl.sv */
// Controller state machine for the priority dispatcher.
// Sequences enqueue and tick transactions; depends on pdts_pkg.
module pdts_ctrl
    import pdts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_cmd_tick,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ENQ    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_ASSIGN = 5'b01000,
        S_STATUS = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a new transaction only when idle
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_cmd_tick == CMD_TICK) ? S_SCAN : S_ENQ;
                end
            end
            S_ENQ: begin
                if (i_status.out_free) begin
                    o_cmd.enq = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_status.srv_busy) begin
                    if (i_status.srv_last) begin
                        n_state = S_STATUS;
                    end else begin
                        o_cmd.srv_next = 1'b1;
                    end
                end else if (!i_status.any_class) begin
                    n_state = S_STATUS;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_ASSIGN;
                end
            end
            S_ASSIGN: begin
                if (i_status.out_free) begin
                    o_cmd.assign_job = 1'b1;
                    if (i_status.srv_last) begin
                        n_state = S_STATUS;
                    end else begin
                        o_cmd.srv_next = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_STATUS: begin
                if (i_status.out_free) begin
                    o_cmd.status = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/pdts_datapath.sv */
// Datapath for the priority dispatcher: class queues in one memory,
// queue pointers, server countdowns and the output register. Depends on pdts_pkg.
module pdts_datapath
    import pdts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_out,
    input  t_cmd      i_cmd,
    output t_status   o_status
);

    // Held transaction
    t_in_item r_item;

    // Queue state
    logic [CNT_W-1:0] r_count [NUM_CLASSES];
    logic [PTR_W-1:0] r_head  [NUM_CLASSES];
    logic [PTR_W-1:0] r_tail  [NUM_CLASSES];
    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [CLS_W-1:0]   r_pop_cls;

    // Servers
    logic [DUR_W-1:0] r_remain [SERVERS];
    logic [SRV_W-1:0] r_srv;

    // Output register
    t_out_item r_out;
    logic      r_out_valid;

    logic [CLS_W-1:0]  w_enq_cls;
    logic              w_full;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CLS_W-1:0]  w_best;
    logic              w_any_class;
    logic              w_any_busy;
    logic              w_any_long;
    logic              w_out_free;
    logic              w_emit;
    t_out_item         w_res;

    // Clamp class three to the lowest class
    assign w_enq_cls = (r_item.customer_class > CLS_W'(NUM_CLASSES - 1))
                     ? CLS_W'(NUM_CLASSES - 1) : r_item.customer_class;
    assign w_full    = (r_count[w_enq_cls] == CNT_W'(CLASS_DEPTH));

    // Pick the best non-empty class
    always_comb begin
        w_best      = CLS_W'(NUM_CLASSES - 1);
        w_any_class = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_count[c] != '0) begin
                w_best      = CLS_W'(c);
                w_any_class = 1'b1;
            end
        end
    end

    // Server activity summary
    always_comb begin
        w_any_busy = 1'b0;
        w_any_long = 1'b0;
        for (int s = 0; s < SERVERS; s++) begin
            if (r_remain[s] != '0) w_any_busy = 1'b1;
            if (r_remain[s] > DUR_W'(1)) w_any_long = 1'b1;
        end
    end

    assign w_wr_addr = ADDR_W'(w_enq_cls) * ADDR_W'(CLASS_DEPTH)
                     + ADDR_W'(r_tail[w_enq_cls]);
    assign w_rd_addr = ADDR_W'(w_best) * ADDR_W'(CLASS_DEPTH)
                     + ADDR_W'(r_head[w_best]);

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_emit     = i_cmd.enq || i_cmd.assign_job || i_cmd.status;

    // Build the result for whichever command emits this cycle
    always_comb begin
        w_res = '0;
        if (i_cmd.enq) begin
            w_res.result_kind  = w_full ? KIND_ENQ_FULL : KIND_ENQ_OK;
            w_res.job_class    = w_enq_cls;
            w_res.job_number   = r_item.customer_number;
            w_res.work_pending = !w_full || w_any_class || w_any_busy;
            w_res.last         = 1'b1;
        end else if (i_cmd.assign_job) begin
            w_res.result_kind  = KIND_ASSIGN;
            w_res.job_class    = r_pop_cls;
            w_res.job_number   = r_rd_data[ENTRY_W-1:DUR_W];
            w_res.server_index = SRVF_W'(r_srv);
        end else begin
            w_res.result_kind  = KIND_TICK_DONE;
            w_res.work_pending = w_any_class || w_any_long;
            w_res.last         = 1'b1;
        end
    end

    assign o_status.srv_busy  = (r_remain[r_srv] != '0);
    assign o_status.srv_last  = (r_srv == SRV_W'(SERVERS - 1));
    assign o_status.any_class = w_any_class;
    assign o_status.out_free  = w_out_free;

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
    end

    // Queue memory: write on enqueue, registered read on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq && !w_full) begin
            mem[w_wr_addr] <= {r_item.customer_number, r_item.call_duration};
        end
        if (i_cmd.pop) begin
            r_rd_data <= mem[w_rd_addr];
            r_pop_cls <= w_best;
        end
    end

    // Queue pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= '0;
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
            end
        end else if (i_cmd.enq && !w_full) begin
            r_count[w_enq_cls] <= r_count[w_enq_cls] + CNT_W'(1);
            r_tail[w_enq_cls]  <= (r_tail[w_enq_cls] == PTR_W'(CLASS_DEPTH - 1))
                                ? '0 : r_tail[w_enq_cls] + PTR_W'(1);
        end else if (i_cmd.pop) begin
            r_count[w_best] <= r_count[w_best] - CNT_W'(1);
            r_head[w_best]  <= (r_head[w_best] == PTR_W'(CLASS_DEPTH - 1))
                             ? '0 : r_head[w_best] + PTR_W'(1);
        end
    end

    // Server scan index and countdowns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv <= '0;
            for (int s = 0; s < SERVERS; s++) begin
                r_remain[s] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_srv <= '0;
            end else if (i_cmd.srv_next) begin
                r_srv <= r_srv + SRV_W'(1);
            end
            if (i_cmd.assign_job) begin
                r_remain[r_srv] <= r_rd_data[DUR_W-1:0];
            end else if (i_cmd.status) begin
                for (int s = 0; s < SERVERS; s++) begin
                    if (r_remain[s] != '0) r_remain[s] <= r_remain[s] - DUR_W'(1);
                end
            end
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_W'(CLASS_DEPTH)) && (r_count[1] <= CNT_W'(CLASS_DEPTH))
        && (r_count[2] <= CNT_W'(CLASS_DEPTH)))
        else $error("class count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> w_any_class)
        else $error("pop with all classes empty");

    a_srv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_srv <= SRV_W'(SERVERS - 1))
        else $error("server index out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_emit)
        else $error("result emitted over a stalled result");

    a_emit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.enq, i_cmd.assign_job, i_cmd.status, i_cmd.pop}))
        else $error("conflicting datapath commands");

endmodule

/* design/priority_dispatch_to_timed_servers_top.sv */
// One transaction in work at a time. An enqueue result is loaded into the output
// register from the enqueue state. An enqueue passes through the accept and enqueue
// states; a tick passes through the accept state, a scan state per server scanned
// without an assignment, a scan and an assign state per assignment, set by the
// registered read of queue memory, and the status state; a stalled result waits.
// Reset clears queue counts, pointers and server countdowns; queue memory is not cleared.
module priority_dispatch_to_timed_servers_top
    import pdts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    pdts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd_tick (i_in.command),
        .o_stall    (o_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Queues, servers and result register
    pdts_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule
